@@ hdl/prp_pkg.sv @@
`default_nettype none
package prp_pkg;

	localparam int SCREEN_W = 1024;
	localparam int SCREEN_H = 1024;
	localparam int DIV_STEPS = 28;
	localparam int Q_DEPTH = 8;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int FRONT_STAGES = 4;
	localparam logic signed [31:0] X_LIMIT = 32'(SCREEN_W * 65536);
	localparam logic signed [31:0] Y_LIMIT = 32'(SCREEN_H * 65536);
	localparam logic signed [31:0] NEG_LIMIT = -32'sd65536;

	typedef enum logic [2:0] {
		REG_COS_PAN      = 3'd0,
		REG_SIN_PAN      = 3'd1,
		REG_COS_TILT     = 3'd2,
		REG_SIN_TILT     = 3'd3,
		REG_CAMERA_DEPTH = 3'd4,
		REG_SCALE_UNIT   = 3'd5,
		REG_CENTER_X     = 3'd6,
		REG_CENTER_Y     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] cos_pan;
		logic signed [15:0] sin_pan;
		logic signed [15:0] cos_tilt;
		logic signed [15:0] sin_tilt;
		logic [30:0] camera_depth;
		logic [30:0] scale_unit;
		logic [9:0] center_x;
		logic [9:0] center_y;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [7:0] glyph;
	} point_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
		logic signed [31:0] depth;
		logic [7:0] glyph_out;
		logic visible;
	} result_t;

	// rotated point and classification handed from front to back
	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y2;
		logic [31:0] divisor;
		logic signed [31:0] depth;
		logic [7:0] glyph;
		logic in_front;
	} entry_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [DIV_STEPS-1:0] lo;
		logic [DIV_STEPS-1:0] quo;
		logic sat;
		logic neg;
	} lane_t;

	typedef struct packed {
		lane_t lx;
		lane_t ly;
		logic [31:0] divisor;
		logic signed [31:0] depth;
		logic [7:0] glyph;
		logic in_front;
	} div_stage_t;

	function automatic logic signed [31:0] rot_scale(input logic signed [48:0] s);
		logic signed [48:0] t;
		logic signed [34:0] q;
		t = s[48] ? s + 49'sd16383 : s;
		q = 35'(t >>> 14);
		if (q > 35'sd2147483647) return 32'sh7fffffff;
		if (q < -35'sd2147483648) return 32'sh80000000;
		return q[31:0];
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7fffffff;
		return v[31:0];
	endfunction

	function automatic lane_t div_step(input lane_t a, input logic [31:0] d);
		lane_t r;
		logic [32:0] sh;
		logic ge;
		r = a;
		sh = {a.rem, a.lo[DIV_STEPS-1]};
		ge = sh >= {1'b0, d};
		r.rem = ge ? 32'(sh - {1'b0, d}) : sh[31:0];
		r.lo = a.lo << 1;
		r.quo = {a.quo[DIV_STEPS-2:0], ge};
		return r;
	endfunction

	function automatic lane_t div_init(input logic [61:0] mag, input logic neg,
			input logic [31:0] d);
		lane_t r;
		logic [33:0] hi;
		hi = mag[61:DIV_STEPS];
		r.sat = hi >= {2'b0, d};
		r.rem = r.sat ? 32'd0 : hi[31:0];
		r.lo = mag[DIV_STEPS-1:0];
		r.quo = '0;
		r.neg = neg;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/prp_front.sv @@
`default_nettype none
module prp_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire prp_pkg::point_t point,
	input  wire prp_pkg::cfg_t cfg,
	output logic out_valid,
	output prp_pkg::entry_t out_entry
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [47:0] p_xc_s1, p_zs_s1, p_xs_s1, p_zc_s1;
	logic signed [31:0] y_s1, y_s2;
	logic [7:0] g_s1, g_s2, g_s3;
	logic signed [31:0] x1_s2, z1_s2, x1_s3;
	logic signed [47:0] p_yc_s3, p_zs_s3, p_zc_s3, p_ys_s3;
	prp_pkg::entry_t e_s4;

	logic signed [48:0] sx, sz, sy2, sz2;
	logic signed [31:0] y2, z2;
	logic signed [32:0] dsum;
	logic ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		sx = 49'(p_xc_s1) - 49'(p_zs_s1);
		sz = 49'(p_xs_s1) + 49'(p_zc_s1);
		sy2 = 49'(p_yc_s3) + 49'(p_zs_s3);
		sz2 = 49'(p_zc_s3) - 49'(p_ys_s3);
		y2 = prp_pkg::rot_scale(sy2);
		z2 = prp_pkg::rot_scale(sz2);
		dsum = 33'(z2) + $signed({2'b00, cfg.camera_depth});
		ok = (33'(z2) < $signed({2'b00, cfg.camera_depth})) && (dsum > 33'sd0);
	end

	always_ff @(posedge clk) begin
		// pan products
		p_xc_s1 <= $signed(point.point_x) * $signed(cfg.cos_pan);
		p_zs_s1 <= $signed(point.point_z) * $signed(cfg.sin_pan);
		p_xs_s1 <= $signed(point.point_x) * $signed(cfg.sin_pan);
		p_zc_s1 <= $signed(point.point_z) * $signed(cfg.cos_pan);
		y_s1 <= point.point_y;
		g_s1 <= point.glyph;
		x1_s2 <= prp_pkg::rot_scale(sx);
		z1_s2 <= prp_pkg::rot_scale(sz);
		y_s2 <= y_s1;
		g_s2 <= g_s1;
		// tilt products
		p_yc_s3 <= y_s2 * $signed(cfg.cos_tilt);
		p_zs_s3 <= z1_s2 * $signed(cfg.sin_tilt);
		p_zc_s3 <= z1_s2 * $signed(cfg.cos_tilt);
		p_ys_s3 <= y_s2 * $signed(cfg.sin_tilt);
		x1_s3 <= x1_s2;
		g_s3 <= g_s2;
		e_s4.x1 <= x1_s3;
		e_s4.y2 <= y2;
		e_s4.divisor <= ok ? dsum[31:0] : 32'd1;
		e_s4.depth <= prp_pkg::sat33(dsum);
		e_s4.glyph <= g_s3;
		e_s4.in_front <= ok;
	end

	assign out_valid = v_s4;
	assign out_entry = e_s4;

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> e_s4.divisor != 32'd0) else $error("zero divisor");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> $past(in_valid, 4)) else $error("front valid chain broken");
`endif

endmodule
`default_nettype wire

@@ hdl/prp_queue.sv @@
`default_nettype none
module prp_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire prp_pkg::entry_t push_entry,
	output logic pop,
	output prp_pkg::entry_t head,
	output logic [prp_pkg::Q_PTR_W:0] count
);

	prp_pkg::entry_t mem_q [prp_pkg::Q_DEPTH];
	logic [prp_pkg::Q_PTR_W-1:0] wr_q, rd_q;
	logic [prp_pkg::Q_PTR_W:0] cnt_q;

	// back side never stalls: head leaves whenever present
	assign pop = cnt_q != '0;
	assign head = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (prp_pkg::Q_PTR_W+1)'(prp_pkg::Q_DEPTH) |-> !push)
		else $error("queue overflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count");
`endif

endmodule
`default_nettype wire

@@ hdl/prp_back.sv @@
`default_nettype none
module prp_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire prp_pkg::entry_t in_entry,
	input  wire prp_pkg::cfg_t cfg,
	output logic result_valid,
	output prp_pkg::result_t result
);

	localparam int N = prp_pkg::DIV_STEPS;

	logic v_s1;
	prp_pkg::entry_t e_s1;
	logic [62:0] mx_s1, my_s1;
	logic nx_s1, ny_s1;
	logic [31:0] ax, ay;

	logic dv_q [N+1];
	prp_pkg::div_stage_t ds_q [N+1];

	logic out_v_q;
	prp_pkg::result_t out_q;

	logic [28:0] tmx, tmy;
	logic signed [31:0] tx, ty, sumx, sumy;
	logic visx, visy, vis;
	prp_pkg::div_stage_t fin;

	always_comb begin
		ax = in_entry.x1[31] ? 32'(-in_entry.x1) : in_entry.x1;
		ay = in_entry.y2[31] ? 32'(-in_entry.y2) : in_entry.y2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= N; i++) dv_q[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			dv_q[0] <= v_s1;
			for (int i = 1; i <= N; i++) dv_q[i] <= dv_q[i-1];
			out_v_q <= dv_q[N];
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= in_entry;
		mx_s1 <= cfg.scale_unit * ax;
		my_s1 <= cfg.scale_unit * ay;
		nx_s1 <= in_entry.x1[31];
		ny_s1 <= ~in_entry.y2[31];
		ds_q[0].lx <= prp_pkg::div_init(mx_s1[61:0], nx_s1, e_s1.divisor);
		ds_q[0].ly <= prp_pkg::div_init(my_s1[61:0], ny_s1, e_s1.divisor);
		ds_q[0].divisor <= e_s1.divisor;
		ds_q[0].depth <= e_s1.depth;
		ds_q[0].glyph <= e_s1.glyph;
		ds_q[0].in_front <= e_s1.in_front;
		for (int i = 1; i <= N; i++) begin
			ds_q[i].divisor <= ds_q[i-1].divisor;
			ds_q[i].depth <= ds_q[i-1].depth;
			ds_q[i].glyph <= ds_q[i-1].glyph;
			ds_q[i].in_front <= ds_q[i-1].in_front;
			ds_q[i].lx <= prp_pkg::div_step(ds_q[i-1].lx, ds_q[i-1].divisor);
			ds_q[i].ly <= prp_pkg::div_step(ds_q[i-1].ly, ds_q[i-1].divisor);
		end
		out_q.pixel_x <= vis ? sumx[25:16] : 10'd0;
		out_q.pixel_y <= vis ? sumy[25:16] : 10'd0;
		out_q.depth <= fin.depth;
		out_q.glyph_out <= fin.glyph;
		out_q.visible <= vis;
	end

	// y lane carries the negated offset so both sums are additions
	always_comb begin
		fin = ds_q[N];
		tmx = fin.lx.sat ? 29'h1000_0000 : 29'(fin.lx.quo);
		tmy = fin.ly.sat ? 29'h1000_0000 : 29'(fin.ly.quo);
		tx = fin.lx.neg ? -32'(tmx) : 32'(tmx);
		ty = fin.ly.neg ? -32'(tmy) : 32'(tmy);
		sumx = $signed({6'd0, cfg.center_x, 16'd0}) + tx;
		sumy = $signed({6'd0, cfg.center_y, 16'd0}) + ty;
		visx = sumx > prp_pkg::NEG_LIMIT && sumx < prp_pkg::X_LIMIT;
		visy = sumy > prp_pkg::NEG_LIMIT && sumy < prp_pkg::Y_LIMIT;
		vis = fin.in_front && visx && visy;
		if (sumx[31]) sumx = '0;
		if (sumy[31]) sumy = '0;
	end

	assign result_valid = out_v_q;
	assign result = out_q;

`ifndef SYNTHESIS
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.visible |-> out_q.pixel_x == 10'd0 && out_q.pixel_y == 10'd0)
		else $error("hidden point has pixel");
	a_sat_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		dv_q[N] && ds_q[N].lx.sat |=> !out_q.visible) else $error("saturated offset visible");
`endif

endmodule
`default_nettype wire

@@ hdl/point_rotate_project.sv @@
`default_nettype none
// point rotation and perspective projection
// input: a point (x, y, z Q16.16, glyph) is taken at a clock edge where start
// is high and busy is low; one point may enter every cycle
// the point is turned by pan then tilt and projected with the camera depth,
// scale and screen center held in eight configuration registers
// configuration: cfg_valid/cfg_ready channel, cfg_index selects the register,
// cfg_data carries the value; cfg_ready is always high; write only while idle
// output: each point gives one transaction on result, marked by result_valid
// for one cycle; the receiver cannot stall, so results leave in input order
// throughput: one point per cycle while busy is low, set by the fully pipelined front rotation
// (4 stages) and the 28-stage restoring divider of the back end
// a queue of 8 entries sits between front and back; busy rises once it holds
// more than 3 entries, so the queue can absorb what is inside the front pipeline
// reset clears all valid flags and loads the register defaults (identity
// rotation, camera depth 10.0, scale 100.0, center 512, 512)
module point_rotate_project (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire prp_pkg::point_t point,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic result_valid,
	output prp_pkg::result_t result
);

	prp_pkg::cfg_t cfg_q;
	logic acc;
	logic f_valid;
	prp_pkg::entry_t f_entry;
	logic q_pop;
	prp_pkg::entry_t q_head;
	logic [prp_pkg::Q_PTR_W:0] q_count;

	assign cfg_ready = 1'b1;
	assign busy = q_count > (prp_pkg::Q_PTR_W+1)'(prp_pkg::Q_DEPTH - 1 - prp_pkg::FRONT_STAGES);
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_pan <= 16'sd16384;
			cfg_q.sin_pan <= 16'sd0;
			cfg_q.cos_tilt <= 16'sd16384;
			cfg_q.sin_tilt <= 16'sd0;
			cfg_q.camera_depth <= 31'd655360;
			cfg_q.scale_unit <= 31'd6553600;
			cfg_q.center_x <= 10'd512;
			cfg_q.center_y <= 10'd512;
		end else if (cfg_valid && cfg_ready) begin
			unique case (prp_pkg::reg_idx_t'(cfg_index))
				prp_pkg::REG_COS_PAN: cfg_q.cos_pan <= cfg_data[15:0];
				prp_pkg::REG_SIN_PAN: cfg_q.sin_pan <= cfg_data[15:0];
				prp_pkg::REG_COS_TILT: cfg_q.cos_tilt <= cfg_data[15:0];
				prp_pkg::REG_SIN_TILT: cfg_q.sin_tilt <= cfg_data[15:0];
				prp_pkg::REG_CAMERA_DEPTH: cfg_q.camera_depth <= cfg_data[30:0];
				prp_pkg::REG_SCALE_UNIT: cfg_q.scale_unit <= cfg_data[30:0];
				prp_pkg::REG_CENTER_X: cfg_q.center_x <= cfg_data[9:0];
				prp_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	prp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .point(point), .cfg(cfg_q),
		.out_valid(f_valid), .out_entry(f_entry)
	);

	prp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .push_entry(f_entry),
		.pop(q_pop), .head(q_head), .count(q_count)
	);

	prp_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_pop), .in_entry(q_head), .cfg(cfg_q),
		.result_valid(result_valid), .result(result)
	);

`ifndef SYNTHESIS
	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_count == '0 |-> !busy) else $error("busy with empty queue");
`endif

endmodule
`default_nettype wire
